// ===== rtl/core/pid_position_velocity_antiwindup_unit_macros.svh =====
// ---------------------------------------------------------------------------
// pid_position_velocity_antiwindup_unit_macros
// Assertion macros used by the checker file ppv_checker.
// ---------------------------------------------------------------------------
`ifndef PID_POSITION_VELOCITY_ANTIWINDUP_UNIT_MACROS_SVH
`define PID_POSITION_VELOCITY_ANTIWINDUP_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define PPV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define PPV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/ppv_pkg.sv =====
// ---------------------------------------------------------------------------
// ppv_pkg
// Types and constants for the position/velocity PID with anti-windup.
// ---------------------------------------------------------------------------
`default_nettype none
package ppv_pkg;
  typedef struct packed {
    logic signed [31:0] pos_target;
    logic signed [31:0] pos_measured;
    logic signed [15:0] vel_target;
    logic signed [15:0] vel_measured;
    logic               clear_integ;
    logic               drive_enable;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic [1:0]         sat_state;
    logic signed [31:0] prop_term;
    logic signed [31:0] integ_term;
    logic signed [31:0] deriv_term;
  } out_item_t;

  localparam logic [2:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [2:0] REG_GAIN_WIND  = 3'd3;
  localparam logic [2:0] REG_FEED_FWD   = 3'd4;
  localparam logic [2:0] REG_LIMIT      = 3'd5;
  localparam logic [2:0] REG_DIVISOR    = 3'd6;

  localparam logic [14:0] LIMIT_RESET = 15'd3800;
  localparam int          PROP_SHIFT  = 12;
  localparam int          TERM_SHIFT  = 4;

  localparam logic [1:0] SAT_NONE = 2'd0;
  localparam logic [1:0] SAT_HIGH = 2'd1;
  localparam logic [1:0] SAT_LOW  = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/core/pid_position_velocity_antiwindup_unit.sv =====
// ---------------------------------------------------------------------------
// pid_position_velocity_antiwindup_unit
// Position/velocity PID tick with clamp and back-calculation anti-windup.
// ---------------------------------------------------------------------------
// A tick forms three 16x32 products, each by one shift-and-add adder at one
// multiplier bit per cycle, then the sum and the clamp, then loads the result
// register, when the sum stays inside the limit. A clamped tick adds the windup
// product and a restoring divider giving one quotient bit per cycle. The next
// item is taken the cycle after the result transfer, so no item is taken while
// the last one is in work or its result waits, and an output stall holds off
// the next item. Configuration writes are taken at any time.
`default_nettype none
module pid_position_velocity_antiwindup_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ppv_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output ppv_pkg::out_item_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [2:0]          cfg_index,
  input  wire  [15:0]         cfg_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // product being formed
  localparam logic [1:0] MUL_P = 2'd0;
  localparam logic [1:0] MUL_I = 2'd1;
  localparam logic [1:0] MUL_D = 2'd2;
  localparam logic [1:0] MUL_W = 2'd3;

  // configuration registers
  logic signed [15:0] kp_r, ki_r, kd_r, kw_r, ff_r;
  logic [14:0] lim_r, div_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0; ki_r <= '0; kd_r <= '0; kw_r <= '0; ff_r <= '0;
      lim_r <= ppv_pkg::LIMIT_RESET; div_r <= 15'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppv_pkg::REG_GAIN_PROP:  kp_r <= cfg_data;
        ppv_pkg::REG_GAIN_INTEG: ki_r <= cfg_data;
        ppv_pkg::REG_GAIN_DERIV: kd_r <= cfg_data;
        ppv_pkg::REG_GAIN_WIND:  kw_r <= cfg_data;
        ppv_pkg::REG_FEED_FWD:   ff_r <= cfg_data;
        ppv_pkg::REG_LIMIT:      lim_r <= cfg_data[14:0];
        ppv_pkg::REG_DIVISOR:    div_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  logic [2:0]  state_r;
  logic [1:0]  mul_sel_r;   // product being formed
  logic [4:0]  cnt_r;
  logic [31:0] integ_r;
  logic [31:0] ep_r, ev_r, mcand_r, acc_r, pt_r, it_r, dt_r, sum_r, drv_r;
  logic [15:0] mplier_r;
  logic [1:0]  sat_r;
  logic        en_r;
  // divider registers
  logic [31:0] dq_r;        // dividend shifting out / quotient in
  logic [15:0] rem_r;
  logic        neg_r;
  logic        out_valid_r;

  // shift-and-add step: signed multiplier, top bit subtracts
  logic [31:0] addend;
  always_comb begin
    addend = mplier_r[0] ? mcand_r : 32'd0;
    if (cnt_r == 5'd15) addend = mplier_r[0] ? (32'd0 - mcand_r) : 32'd0;
  end

  logic signed [31:0] s_sum, lim_s;
  assign s_sum = sum_r;
  assign lim_s = {17'd0, lim_r};
  logic [15:0] divisor;
  assign divisor = (div_r == 15'd0) ? 16'd1 : {1'b0, div_r};
  logic [16:0] rem_try;
  assign rem_try = {rem_r, dq_r[31]} - {1'b0, divisor};

  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      integ_r <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            ep_r <= in_data.pos_target - in_data.pos_measured;
            ev_r <= 32'(32'(signed'(in_data.vel_target))
                        - 32'(signed'(in_data.vel_measured)));
            if (in_data.clear_integ) integ_r <= '0;
            en_r <= in_data.drive_enable;
            mcand_r <= in_data.pos_target - in_data.pos_measured;
            mplier_r <= kp_r;
            mul_sel_r <= MUL_P;
            cnt_r <= '0;
            acc_r <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt_r == 5'd15) begin
            // last multiplier bit: store the product, load the next one
            cnt_r <= '0;
            acc_r <= '0;
            case (mul_sel_r)
              MUL_P: begin
                pt_r <= 32'($signed(acc_r + addend) >>> ppv_pkg::PROP_SHIFT);
                mcand_r <= (integ_r); mplier_r <= ki_r; mul_sel_r <= MUL_I;
              end
              MUL_I: begin
                it_r <= acc_r + addend;
                mcand_r <= ev_r; mplier_r <= kd_r; mul_sel_r <= MUL_D;
              end
              MUL_D: begin
                dt_r <= acc_r + addend;
                state_r <= ST_SUM;
              end
              default: begin
                // windup product ready: set up divider on its magnitude
                neg_r <= (acc_r + addend) >> 31 != 32'd0;
                dq_r <= ((acc_r + addend) >> 31 != 32'd0) ?
                        (32'd0 - (acc_r + addend)) : (acc_r + addend);
                rem_r <= '0;
                state_r <= ST_DIV;
              end
            endcase
          end else begin
            // one multiplier bit per cycle
            acc_r <= acc_r + addend;
            mcand_r <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_SUM: begin
          // sum and clamp in two phases, using mul_sel_r as the phase
          if (mul_sel_r == MUL_D) begin
            sum_r <= 32'(signed'(ff_r)) + pt_r
                     + 32'($signed(it_r) >>> ppv_pkg::TERM_SHIFT)
                     + 32'($signed(dt_r) >>> ppv_pkg::TERM_SHIFT);
            integ_r <= integ_r + ep_r;
            mul_sel_r <= MUL_P;
          end else begin
            if (s_sum > lim_s) begin
              sat_r <= ppv_pkg::SAT_HIGH; drv_r <= lim_s;
              mcand_r <= lim_s - sum_r; mplier_r <= kw_r;
              mul_sel_r <= MUL_W; state_r <= ST_MUL;
            end else if (s_sum < -lim_s) begin
              sat_r <= ppv_pkg::SAT_LOW; drv_r <= -lim_s;
              mcand_r <= -lim_s - sum_r; mplier_r <= kw_r;
              mul_sel_r <= MUL_W; state_r <= ST_MUL;
            end else begin
              sat_r <= ppv_pkg::SAT_NONE; drv_r <= sum_r;
              state_r <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!rem_try[16]) rem_r <= rem_try[15:0];
          else rem_r <= {rem_r[14:0], dq_r[31]};
          dq_r <= {dq_r[30:0], ~rem_try[16]};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            integ_r <= integ_r + (neg_r ? 32'd0 - {dq_r[30:0], ~rem_try[16]}
                                        : {dq_r[30:0], ~rem_try[16]});
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_data.drive <= en_r ? drv_r[15:0] : 16'd0;
          out_data.sat_state <= sat_r;
          out_data.prop_term <= pt_r;
          out_data.integ_term <= it_r;
          out_data.deriv_term <= dt_r;
          out_valid_r <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ppv_checker.sv =====
// ---------------------------------------------------------------------------
// ppv_checker
// Port-level checks on the PID unit, bound into the PID unit module.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pid_position_velocity_antiwindup_unit_macros.svh"
module ppv_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input ppv_pkg::out_item_t out_data
);
  // no input transfer while a result waits
  `PPV_ASSERT_IMP(a_hold_in, clk, rst_n, out_valid, in_stall, "input taken with result pending")
  // a result is never clamped both ways
  `PPV_ASSERT_IMP(a_sat_code, clk, rst_n, out_valid, out_data.sat_state != 2'd3, "bad sat code")
  // a transfer starts work: no result next cycle
  `PPV_ASSERT_NXT(a_no_instant, clk, rst_n, in_valid && !in_stall, !out_valid, "result too early")
  // stalled result holds
  `PPV_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result dropped")
endmodule
bind pid_position_velocity_antiwindup_unit ppv_checker u_ppv_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID tick unit testbench
// Drives control ticks through the PID unit under several gain, limit and
// divisor settings, predicts each result from a behavioral copy of the
// controller, and checks drive, saturation and telemetry terms per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  localparam int NUM_RANDOM  = 700;
  localparam int DRAIN_WAIT  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ppv_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ppv_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pid_position_velocity_antiwindup_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // controller copy: registers and integrator
  logic signed [15:0] kp, ki, kd, kaw, ffwd;
  logic [14:0] lim_reg, div_reg;
  logic [31:0] integ;
  ppv_pkg::out_item_t expected_q[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_sat = 0;
  bit quiet = 1'b0;

  function automatic logic [31:0] gmul(logic signed [15:0] g, logic [31:0] w);
    logic signed [63:0] p;
    p = 64'(g) * 64'(signed'(w));
    return p[31:0];
  endfunction

  // one control tick of the controller
  function automatic ppv_pkg::out_item_t tick(ppv_pkg::in_item_t t);
    ppv_pkg::out_item_t r;
    logic [31:0] ep, ev, sum, excess, corr;
    logic signed [31:0] s, lim;
    logic signed [63:0] q;
    if (t.clear_integ) integ = '0;
    ep = t.pos_target - t.pos_measured;
    ev = 32'(signed'(t.vel_target)) - 32'(signed'(t.vel_measured));
    r.prop_term = signed'(gmul(kp, ep)) >>> ppv_pkg::PROP_SHIFT;
    r.integ_term = gmul(ki, integ);
    r.deriv_term = gmul(kd, ev);
    sum = 32'(signed'(ffwd)) + r.prop_term + (r.integ_term >>> ppv_pkg::TERM_SHIFT)
        + (r.deriv_term >>> ppv_pkg::TERM_SHIFT);
    s = signed'(sum);
    integ = integ + ep;
    lim = 32'(lim_reg);
    r.sat_state = ppv_pkg::SAT_NONE;
    if (s > lim) begin
      r.sat_state = ppv_pkg::SAT_HIGH;
      s = lim;
    end else if (s < -lim) begin
      r.sat_state = ppv_pkg::SAT_LOW;
      s = -lim;
    end
    if (r.sat_state != ppv_pkg::SAT_NONE) begin
      excess = s - sum;
      q = 64'(signed'(gmul(kaw, excess)))
          / signed'(64'(div_reg == 15'd0 ? 15'd1 : div_reg));
      corr = q[31:0];
      integ = integ + corr;
    end
    r.drive = t.drive_enable ? s[15:0] : 16'sd0;
    return r;
  endfunction

  // one register write; valid stays up for a following write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ppv_pkg::REG_GAIN_PROP:  kp = val;
      ppv_pkg::REG_GAIN_INTEG: ki = val;
      ppv_pkg::REG_GAIN_DERIV: kd = val;
      ppv_pkg::REG_GAIN_WIND:  kaw = val;
      ppv_pkg::REG_FEED_FWD:   ffwd = val;
      ppv_pkg::REG_LIMIT:      lim_reg = val[14:0];
      ppv_pkg::REG_DIVISOR:    div_reg = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                         logic [15:0] w, logic [15:0] f, logic [14:0] l,
                         logic [14:0] dv);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    write_reg(ppv_pkg::REG_GAIN_PROP, p);
    write_reg(ppv_pkg::REG_GAIN_INTEG, i);
    write_reg(ppv_pkg::REG_GAIN_DERIV, d);
    write_reg(ppv_pkg::REG_GAIN_WIND, w);
    write_reg(ppv_pkg::REG_FEED_FWD, f);
    write_reg(ppv_pkg::REG_LIMIT, {1'b0, l});
    write_reg(ppv_pkg::REG_DIVISOR, {1'b0, dv});
    cfg_valid <= 1'b0;
  endtask

  // one input transfer; an optional typed-in expectation overrides the predictor
  task automatic send(ppv_pkg::in_item_t t, bit has_exp = 0,
                      ppv_pkg::out_item_t ex = '0);
    ppv_pkg::out_item_t r;
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    r = tick(t);
    if (has_exp) r = ex;
    expected_q.push_back(r);
    if (r.sat_state != ppv_pkg::SAT_NONE) n_sat++;
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // result side: random stall, compare each transfer against the oldest expectation
  always @(posedge clk) begin
    ppv_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_got++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.drive !== e.drive) begin
          $error("drive exp %0d got %0d", e.drive, out_data.drive); errors++;
        end
        if (out_data.sat_state !== e.sat_state) begin
          $error("sat_state exp %0d got %0d", e.sat_state, out_data.sat_state); errors++;
        end
        if (out_data.prop_term !== e.prop_term) begin
          $error("prop_term exp %0d got %0d", e.prop_term, out_data.prop_term); errors++;
        end
        if (out_data.integ_term !== e.integ_term) begin
          $error("integ_term exp %0d got %0d", e.integ_term, out_data.integ_term);
          errors++;
        end
        if (out_data.deriv_term !== e.deriv_term) begin
          $error("deriv_term exp %0d got %0d", e.deriv_term, out_data.deriv_term);
          errors++;
        end
      end
    end
    out_stall <= (!quiet && rst_n && $urandom_range(99) < 8);
  end

  function automatic ppv_pkg::in_item_t mk(logic [31:0] pt, logic [31:0] pm,
                                           logic [15:0] vt, logic [15:0] vm,
                                           logic clr, logic en);
    ppv_pkg::in_item_t t;
    t.pos_target = pt; t.pos_measured = pm;
    t.vel_target = vt; t.vel_measured = vm;
    t.clear_integ = clr; t.drive_enable = en;
    return t;
  endfunction

  function automatic logic [31:0] rnd_pos();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(8000)) - 4000);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic logic [15:0] rnd16();
    return $urandom_range(3) == 0 ? ($urandom_range(1) ? 16'h7fff : 16'h8000)
                                  : 16'($urandom());
  endfunction

  ppv_pkg::in_item_t dir_tbl[$];
  initial begin
    ppv_pkg::out_item_t ex;
    ppv_pkg::in_item_t t;
    kp = 0; ki = 0; kd = 0; kaw = 0; ffwd = 0;
    lim_reg = ppv_pkg::LIMIT_RESET; div_reg = 1; integ = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset all gains are zero: every term and the drive read zero
    ex = '0;
    send(mk(32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000, 1'b0, 1'b1), 1, ex);
    send(mk('0, '0, '0, '0, 1'b1, 1'b0), 1, ex);

    // directed table: extremes, clamp both ways, disabled drive, clear, wraps
    set_all(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 15'd1);
    dir_tbl = '{
      mk(32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000, 1'b0, 1'b1),
      mk(32'h80000000, 32'h7fffffff, 16'h8000, 16'h7fff, 1'b0, 1'b1),
      mk(32'd1000, 32'd0, 16'd5, 16'd0, 1'b0, 1'b0),
      mk(32'hffffffff, 32'h0, 16'hffff, 16'h0, 1'b1, 1'b1),
      mk(32'h12345678, 32'h87654321, 16'h1234, 16'h4321, 1'b0, 1'b1)};
    foreach (dir_tbl[i]) send(dir_tbl[i]);
    set_all(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 15'd0, 15'd0);
    foreach (dir_tbl[i]) send(dir_tbl[i]);
    send(mk('0, '0, '0, '0, 1'b1, 1'b1));
    set_all(16'd4096, 16'd16, 16'd16, 16'd3, 16'd0, 15'd100, 15'd7);
    foreach (dir_tbl[i]) send(dir_tbl[i]);
    send(mk(32'd50, 32'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    send(mk(32'd150, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1));
    send(mk(32'hffffff00, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1));

    // random ticks, settings changed in phases; a quiet stretch in the middle
    for (int ph = 0; ph < 7; ph++) begin
      quiet = (ph == 3);
      set_all(16'($signed($urandom_range(8000)) - 4000), rnd16(),
              16'($signed($urandom_range(400)) - 200), rnd16(),
              16'($signed($urandom_range(2000)) - 1000),
              ph == 0 ? 15'd0 : 15'($urandom_range(5000)),
              ph == 1 ? 15'h7fff : 15'($urandom_range(1, 300)));
      for (int k = 0; k < NUM_RANDOM / 7; k++) begin
        t = mk(rnd_pos(), rnd_pos(), rnd16(), rnd16(),
               $urandom_range(15) == 0, $urandom_range(7) != 0);
        send(t);
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d ticks over 11 register settings, %0d clamped.",
             n_sent, n_sat);
    $display("Results checked: %0d.", n_got);
    if (errors == 0 && expected_q.size() == 0)
      $display("PASS pid_position_velocity_antiwindup_unit");
    else
      $display("FAIL pid_position_velocity_antiwindup_unit");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAIL pid_position_velocity_antiwindup_unit");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ppv_pkg.sv
rtl/core/pid_position_velocity_antiwindup_unit.sv
rtl/core/ppv_checker.sv
bench/tb.sv
